>>> rtl/brfcr_pkg.sv
`timescale 1ns / 1ps

package brfcr_pkg;

   localparam int CAPACITY = 4096;
   localparam int MAX_READ = 64;

   localparam int PTR_W  = $clog2(CAPACITY);
   localparam int CNT_W  = 13;
   localparam int LEN_W  = 13;
   localparam int GEN_W  = 32;
   localparam int REM_W  = $clog2(MAX_READ + 1);
   localparam int BYTE_W = 8;

   typedef enum logic [2:0] {
      CMD_OPEN     = 3'd0,
      CMD_BYTE     = 3'd1,
      CMD_READ_AV  = 3'd2,
      CMD_READ_EX  = 3'd3,
      CMD_DISCARD  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK     = 2'd0,
      STS_REJECT = 2'd1,
      STS_STRAY  = 2'd2
   } status_type;

   typedef struct packed {
      logic              en;
      logic [PTR_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
   } ram_rd_type;

endpackage

>>> rtl/brfcr_ram.sv
`timescale 1ns / 1ps

module brfcr_ram
   import brfcr_pkg::*;
(
   input  logic              clock,
   input  ram_wr_type        wr,
   input  ram_rd_type        rd,
   output logic [BYTE_W-1:0] rdata
);

   logic [BYTE_W-1:0] mem [CAPACITY];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata_ff <= mem[rd.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/byte_ring_fifo_commit_read_top.sv
`timescale 1ns / 1ps
// Non-read items: result registered the cycle after the transfer.
// Reads of n bytes: bytes come from the single-port-read byte store, one byte per
// cycle while the output is free; no new item is taken until the last byte is loaded.
// Output stalls hold the block; a new item is taken no earlier than the cycle in
// which the pending result transfers.
// Synchronous active-high reset clears pointers, counts and commit state; the
// byte store is not cleared and needs no clearing pass.

module byte_ring_fifo_commit_read_top
   import brfcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // cmd[2:0]
   input  logic [23:0] req_tdata,   // length[12:0], data_byte[20:13], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,   // has_data[0]
   output logic [71:0] rsp_tdata    // status[1:0], read_byte[9:2], dropped_count[22:10],
                                    // available_count[35:23], generation[67:36], zero pad
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type          state_ff,   state_in;
   logic [PTR_W-1:0]   rp_ff,      rp_in;
   logic [CNT_W-1:0]   vis_ff,     vis_in;
   logic [GEN_W-1:0]   gen_ff,     gen_in;
   logic               active_ff,  active_in;
   logic [CNT_W-1:0]   total_ff,   total_in;
   logic [CNT_W-1:0]   staged_ff,  staged_in;
   logic [REM_W-1:0]   remain_ff,  remain_in;
   logic               fetched_ff, fetched_in;

   logic               valid_ff,   valid_in;
   status_type         sts_ff,     sts_in;
   logic               has_ff,     has_in;
   logic [BYTE_W-1:0]  byte_ff,    byte_in;
   logic               last_ff,    last_in;
   logic [CNT_W-1:0]   disc_ff,    disc_in;

   ram_wr_type         ram_wr;
   ram_rd_type         ram_rd;
   logic [BYTE_W-1:0]  ram_rdata;

   cmd_type            cmd;
   logic [LEN_W-1:0]   len;
   logic [BYTE_W-1:0]  data_byte;
   logic               out_free;
   logic               accept;
   logic [CNT_W-1:0]   free_space;
   logic [CNT_W-1:0]   cap_len;
   logic [CNT_W-1:0]   rd_count;
   logic [CNT_W-1:0]   staged_next;

   assign cmd       = cmd_type'(req_tuser);
   assign len       = req_tdata[LEN_W-1:0];
   assign data_byte = req_tdata[LEN_W +: BYTE_W];

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;

   assign free_space  = CNT_W'(CAPACITY) - vis_ff;
   assign cap_len     = (len > LEN_W'(MAX_READ)) ? CNT_W'(MAX_READ) : len;
   assign rd_count    = (cap_len > vis_ff) ? vis_ff : cap_len;
   assign staged_next = staged_ff + CNT_W'(1);

   always_comb begin
      state_in   = state_ff;
      rp_in      = rp_ff;
      vis_in     = vis_ff;
      gen_in     = gen_ff;
      active_in  = active_ff;
      total_in   = total_ff;
      staged_in  = staged_ff;
      remain_in  = remain_ff;
      fetched_in = fetched_ff;
      valid_in   = rsp_tready ? 1'b0 : valid_ff;
      sts_in     = sts_ff;
      has_in     = has_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      disc_in    = disc_ff;
      ram_wr     = '0;
      ram_rd.en   = 1'b0;
      ram_rd.addr = rp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               valid_in = 1'b1;
               sts_in   = STS_OK;
               has_in   = 1'b0;
               byte_in  = '0;
               last_in  = 1'b1;
               disc_in  = '0;
               case (cmd)
                  CMD_OPEN: begin
                     if (active_ff || len > free_space) begin
                        sts_in = STS_REJECT;
                     end else if (len != '0) begin
                        active_in = 1'b1;
                        total_in  = len;
                        staged_in = '0;
                     end
                  end
                  CMD_BYTE: begin
                     if (!active_ff) begin
                        sts_in = STS_STRAY;
                     end else begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = rp_ff + vis_ff[PTR_W-1:0] + staged_ff[PTR_W-1:0];
                        ram_wr.data = data_byte;
                        if (staged_next >= total_ff) begin
                           vis_in    = vis_ff + total_ff;
                           gen_in    = gen_ff + GEN_W'(1);
                           active_in = 1'b0;
                           total_in  = '0;
                           staged_in = '0;
                        end else begin
                           staged_in = staged_next;
                        end
                     end
                  end
                  CMD_READ_AV, CMD_READ_EX: begin
                     if (cmd == CMD_READ_EX && (len > vis_ff || len > LEN_W'(MAX_READ))) begin
                        sts_in = STS_REJECT;
                     end else if ((cmd == CMD_READ_EX ? len : rd_count) != '0) begin
                        // no result yet; bytes follow from the store
                        valid_in   = 1'b0;
                        state_in   = ST_READ;
                        remain_in  = (cmd == CMD_READ_EX) ? REM_W'(len) : REM_W'(rd_count);
                        ram_rd.en  = 1'b1;
                        fetched_in = 1'b1;
                     end
                  end
                  CMD_DISCARD: begin
                     if (active_ff || vis_ff != len) begin
                        sts_in = STS_REJECT;
                     end else begin
                        disc_in = vis_ff;
                        rp_in   = '0;
                        vis_in  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (!fetched_ff) begin
               ram_rd.en  = 1'b1;
               fetched_in = 1'b1;
            end else if (out_free) begin
               valid_in  = 1'b1;
               sts_in    = STS_OK;
               has_in    = 1'b1;
               byte_in   = ram_rdata;
               last_in   = (remain_ff == REM_W'(1));
               disc_in   = '0;
               rp_in     = rp_ff + PTR_W'(1);
               vis_in    = vis_ff - CNT_W'(1);
               remain_in = remain_ff - REM_W'(1);
               if (remain_ff == REM_W'(1)) begin
                  state_in   = ST_IDLE;
                  fetched_in = 1'b0;
               end else begin
                  ram_rd.en   = 1'b1;
                  ram_rd.addr = rp_ff + PTR_W'(1);
                  fetched_in  = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rp_ff      <= '0;
         vis_ff     <= '0;
         gen_ff     <= '0;
         active_ff  <= 1'b0;
         total_ff   <= '0;
         staged_ff  <= '0;
         remain_ff  <= '0;
         fetched_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rp_ff      <= rp_in;
         vis_ff     <= vis_in;
         gen_ff     <= gen_in;
         active_ff  <= active_in;
         total_ff   <= total_in;
         staged_ff  <= staged_in;
         remain_ff  <= remain_in;
         fetched_ff <= fetched_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sts_ff  <= sts_in;
      has_ff  <= has_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      disc_ff <= disc_in;
   end

   brfcr_ram u_ram (
      .clock (clock),
      .wr    (ram_wr),
      .rd    (ram_rd),
      .rdata (ram_rdata)
   );

   // counts and generation only move together with a result load
   assign rsp_tvalid   = valid_ff;
   assign rsp_tlast    = last_ff;
   assign rsp_tuser[0] = has_ff;
   assign rsp_tdata    = {4'b0, gen_ff, vis_ff, disc_ff, byte_ff, sts_ff};

   a_vis_bound: assert property (@(posedge clock) disable iff (reset)
      vis_ff <= CNT_W'(CAPACITY))
      else $error("visible count above capacity");

   a_read_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> remain_ff != '0 && fetched_ff)
      else $error("read state without pending byte");

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> staged_ff < total_ff && {1'b0, vis_ff} + {1'b0, total_ff} <= 14'(CAPACITY))
      else $error("open commit exceeds room");

   a_read_end_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ && $past(state_ff) == ST_READ && state_ff != state_in |-> out_free)
      else $error("read finished without result slot");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb
   import brfcr_pkg::*;
();

   localparam logic [2:0] CMD_SPARE_LO = 3'd5;
   localparam logic [2:0] CMD_SPARE_HI = 3'd7;
   localparam int DIR_ROWS = 25;

   typedef struct packed {
      status_type        sts;
      logic              has_data;
      logic [7:0]        rd_byte;
      logic              last;
      logic [CNT_W-1:0]  dropped;
      logic [CNT_W-1:0]  avail;
      logic [GEN_W-1:0]  gen;
   } rsp_rec_type;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [LEN_W-1:0]  len;
      logic [7:0]        data;
      logic              pin;
      status_type        sts;
      logic [CNT_W-1:0]  avail;
      logic [GEN_W-1:0]  gen;
   } dir_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;   // cmd[2:0]
   logic [23:0] req_tdata = '0;   // length[12:0], data_byte[20:13], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;        // has_data[0]
   logic [71:0] rsp_tdata;        // status[1:0], read_byte[9:2], dropped_count[22:10],
                                  // available_count[35:23], generation[67:36], zero pad

   // ring shadow
   logic [7:0]       ring_bytes [CAPACITY];
   logic [PTR_W-1:0] rd_ptr = '0;
   int               fill = 0;
   logic [GEN_W-1:0] gen_cnt = '0;
   bit               wr_open = 1'b0;
   int               wr_total = 0;
   int               wr_staged = 0;

   rsp_rec_type rsp_due [$];
   int       mismatches = 0;
   int       items_sent = 0;
   int       snd_idle_pct = 13;
   int       rcv_idle_pct = 72;
   int       rcv_hold = 0;

   dir_row_type dir_steps [DIR_ROWS] = '{
      '{CMD_READ_AV,  13'd5,    8'hFF, 1'b1, STS_OK,     13'd0, 32'd0},
      '{CMD_BYTE,     13'd8191, 8'hFF, 1'b1, STS_STRAY,  13'd0, 32'd0},
      '{CMD_READ_EX,  13'd1,    8'h00, 1'b1, STS_REJECT, 13'd0, 32'd0},
      '{CMD_DISCARD,  13'd1,    8'h00, 1'b1, STS_REJECT, 13'd0, 32'd0},
      '{CMD_DISCARD,  13'd0,    8'h00, 1'b1, STS_OK,     13'd0, 32'd0},
      '{CMD_OPEN,     13'd4097, 8'h00, 1'b1, STS_REJECT, 13'd0, 32'd0},
      '{CMD_OPEN,     13'd0,    8'h00, 1'b1, STS_OK,     13'd0, 32'd0},
      '{CMD_OPEN,     13'd3,    8'h00, 1'b1, STS_OK,     13'd0, 32'd0},
      '{CMD_OPEN,     13'd1,    8'h00, 1'b1, STS_REJECT, 13'd0, 32'd0},
      '{CMD_DISCARD,  13'd0,    8'h00, 1'b1, STS_REJECT, 13'd0, 32'd0},
      '{CMD_READ_EX,  13'd0,    8'h00, 1'b0, STS_OK,     13'd0, 32'd0},
      '{CMD_BYTE,     13'd0,    8'h00, 1'b0, STS_OK,     13'd0, 32'd0},
      '{CMD_BYTE,     13'd8191, 8'hFF, 1'b0, STS_OK,     13'd0, 32'd0},
      '{CMD_BYTE,     13'd0,    8'hA5, 1'b0, STS_OK,     13'd0, 32'd0},
      '{CMD_SPARE_HI, 13'd8191, 8'hFF, 1'b0, STS_OK,     13'd0, 32'd0},
      '{CMD_READ_EX,  13'd4,    8'h00, 1'b1, STS_REJECT, 13'd3, 32'd1},
      '{CMD_READ_EX,  13'd65,   8'h00, 1'b1, STS_REJECT, 13'd3, 32'd1},
      '{CMD_READ_AV,  13'd2,    8'h00, 1'b0, STS_OK,     13'd0, 32'd0},
      '{CMD_OPEN,     13'd2,    8'h00, 1'b0, STS_OK,     13'd0, 32'd0},
      '{CMD_BYTE,     13'd0,    8'h5A, 1'b0, STS_OK,     13'd0, 32'd0},
      '{CMD_BYTE,     13'd0,    8'hC3, 1'b0, STS_OK,     13'd0, 32'd0},
      '{CMD_READ_AV,  13'd8191, 8'h00, 1'b0, STS_OK,     13'd0, 32'd0},
      '{CMD_OPEN,     13'd1,    8'h00, 1'b0, STS_OK,     13'd0, 32'd0},
      '{CMD_BYTE,     13'd0,    8'h7E, 1'b0, STS_OK,     13'd0, 32'd0},
      '{CMD_DISCARD,  13'd1,    8'h00, 1'b0, STS_OK,     13'd0, 32'd0}
   };

   byte_ring_fifo_commit_read_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void log_result(input status_type sts, input logic has,
                                      input logic [7:0] b, input logic last,
                                      input int dropped);
      rsp_due.push_back('{sts, has, b, last, CNT_W'(dropped), CNT_W'(fill), gen_cnt});
   endfunction

   task automatic pop_bytes(input int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = ring_bytes[rd_ptr];
         rd_ptr = rd_ptr + 1'b1;
         fill--;
         log_result(STS_OK, 1'b1, b, i == n - 1, 0);
      end
   endtask

   task automatic predict_ring_item(input logic [2:0] cmd, input logic [LEN_W-1:0] len,
                                    input logic [7:0] data);
      logic [PTR_W-1:0] waddr;
      int n;
      n = int'(len);
      case (cmd)
         CMD_OPEN: begin
            if (wr_open || n > CAPACITY - fill) begin
               log_result(STS_REJECT, 1'b0, 8'h00, 1'b1, 0);
            end else begin
               if (n != 0) begin
                  wr_open = 1'b1;
                  wr_total = n;
                  wr_staged = 0;
               end
               log_result(STS_OK, 1'b0, 8'h00, 1'b1, 0);
            end
         end
         CMD_BYTE: begin
            if (!wr_open) begin
               log_result(STS_STRAY, 1'b0, 8'h00, 1'b1, 0);
            end else begin
               waddr = rd_ptr + PTR_W'(fill + wr_staged);
               ring_bytes[waddr] = data;
               wr_staged++;
               if (wr_staged >= wr_total) begin
                  fill += wr_total;
                  gen_cnt = gen_cnt + 1'b1;
                  wr_open = 1'b0;
                  wr_total = 0;
                  wr_staged = 0;
               end
               log_result(STS_OK, 1'b0, 8'h00, 1'b1, 0);
            end
         end
         CMD_READ_AV: begin
            if (n > MAX_READ) n = MAX_READ;
            if (n > fill) n = fill;
            if (n == 0) log_result(STS_OK, 1'b0, 8'h00, 1'b1, 0);
            else pop_bytes(n);
         end
         CMD_READ_EX: begin
            if (n > fill || n > MAX_READ) log_result(STS_REJECT, 1'b0, 8'h00, 1'b1, 0);
            else if (n == 0) log_result(STS_OK, 1'b0, 8'h00, 1'b1, 0);
            else pop_bytes(n);
         end
         CMD_DISCARD: begin
            if (wr_open || fill != n) begin
               log_result(STS_REJECT, 1'b0, 8'h00, 1'b1, 0);
            end else begin
               n = fill;
               rd_ptr = '0;
               fill = 0;
               log_result(STS_OK, 1'b0, 8'h00, 1'b1, n);
            end
         end
         default: log_result(STS_OK, 1'b0, 8'h00, 1'b1, 0);
      endcase
   endtask

   // valid is only lowered during a gap, so back-to-back items keep it high
   task automatic offer(input logic [2:0] cmd, input logic [LEN_W-1:0] len,
                        input logic [7:0] data);
      @(negedge clock);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, data, len};
      do @(posedge clock); while (!req_tready);
      predict_ring_item(cmd, len, data);
      items_sent++;
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
   endtask

   task automatic commit_run(input int len, input int nbytes, input bit mixed);
      offer(CMD_OPEN, LEN_W'(len), 8'($urandom));
      for (int i = 0; i < nbytes; i++) begin
         if (mixed && $urandom_range(0, 99) < 12)
            offer($urandom_range(0, 1) ? CMD_READ_AV : CMD_READ_EX,
                  LEN_W'($urandom_range(0, 20)), 8'($urandom));
         offer(CMD_BYTE, LEN_W'($urandom), 8'($urandom));
      end
   endtask

   task automatic random_mix(input int target);
      int pick;
      int len;
      int nb;
      while (items_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300)
                                               : $urandom_range(1, 24);
            if (len > CAPACITY - fill) len = CAPACITY - fill;
            // now and then a commit is cut short or overrun
            nb = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len + 2) : len;
            if (len == 0) offer(CMD_READ_AV, LEN_W'(MAX_READ), 8'($urandom));
            else commit_run(len, nb, 1'b1);
         end else if (pick < 75) begin
            if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 8191);
            else if ($urandom_range(0, 9) == 0) len = fill;
            else len = $urandom_range(0, 70);
            offer($urandom_range(0, 1) ? CMD_READ_AV : CMD_READ_EX, LEN_W'(len),
                  8'($urandom));
         end else if (pick < 85) begin
            case ($urandom_range(0, 3))
               0, 1: len = fill;
               2: len = fill + 1;
               default: len = $urandom_range(0, 8191);
            endcase
            offer(CMD_DISCARD, LEN_W'(len), 8'($urandom));
         end else begin
            case ($urandom_range(0, 2))
               0: offer(CMD_BYTE, LEN_W'($urandom), 8'($urandom));
               1: offer(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                        LEN_W'($urandom), 8'($urandom));
               default: offer(CMD_OPEN, LEN_W'($urandom), 8'($urandom));
            endcase
         end
      end
   endtask

   // space and read-size limits, exact and mismatched discard
   task automatic capacity_sweep();
      int left;
      left = wr_open ? wr_total - wr_staged : 0;
      repeat (left) offer(CMD_BYTE, LEN_W'($urandom), 8'($urandom));
      while (fill > 0) offer(CMD_READ_AV, LEN_W'(MAX_READ), 8'($urandom));
      commit_run(MAX_READ + 8, MAX_READ + 8, 1'b0);
      offer(CMD_OPEN, LEN_W'(CAPACITY - fill + 1), 8'($urandom));
      offer(CMD_READ_EX, LEN_W'(MAX_READ + 1), 8'($urandom));
      offer(CMD_READ_EX, LEN_W'(MAX_READ), 8'($urandom));
      offer(CMD_READ_AV, LEN_W'(8191), 8'($urandom));
      commit_run(3, 3, 1'b0);
      offer(CMD_DISCARD, LEN_W'(2), 8'($urandom));
      offer(CMD_DISCARD, LEN_W'(3), 8'($urandom));
   endtask

   always @(negedge clock) begin
      if (rcv_hold > 0) begin
         rcv_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: transfer expected none, got tdata %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = rsp_due.pop_front();
            check_field("status", 32'(want.sts), 32'(rsp_tdata[1:0]));
            check_field("has_data", 32'(want.has_data), 32'(rsp_tuser[0]));
            check_field("read_byte", 32'(want.rd_byte), 32'(rsp_tdata[9:2]));
            check_field("last", 32'(want.last), 32'(rsp_tlast));
            check_field("dropped_count", 32'(want.dropped), 32'(rsp_tdata[22:10]));
            check_field("available_count", 32'(want.avail), 32'(rsp_tdata[35:23]));
            check_field("generation", want.gen, rsp_tdata[67:36]);
         end
      end
   end

   initial begin
      int len;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_steps[k]) begin
         offer(dir_steps[k].cmd, dir_steps[k].len, dir_steps[k].data);
         if (dir_steps[k].pin)
            rsp_due[rsp_due.size() - 1] = '{dir_steps[k].sts, 1'b0, 8'h00, 1'b1,
                                            13'd0, dir_steps[k].avail, dir_steps[k].gen};
      end
      random_mix(items_sent + 160);
      wait_quiet();

      snd_idle_pct = 72;
      rcv_idle_pct = 13;
      random_mix(items_sent + 140);
      wait_quiet();

      // long receiver hold while items keep coming
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      rcv_hold = 400;
      len = CAPACITY - fill;
      if (len > 60) len = 60;
      if (len > 0) commit_run(len, len, 1'b0);
      repeat (8) offer(CMD_READ_AV, LEN_W'(MAX_READ), 8'($urandom));
      wait_quiet();

      capacity_sweep();
      random_mix(items_sent + 50);
      wait_quiet();
      repeat (20) @(posedge clock);

      if (mismatches == 0) begin
         $display("PASS byte_ring_fifo_commit_read_top");
      end else begin
         $display("FAIL byte_ring_fifo_commit_read_top");
      end
      $finish;
   end

   initial begin
      #24_000_000;
      $display("FAIL byte_ring_fifo_commit_read_top");
      $finish;
   end

endmodule
